@@ rtl/sphist_pkg.sv @@
// Shared types, constants and codes of the symbol pair histogram.
`default_nettype none
package sphist_pkg;

  // Default parameter values handed to the top level.
  localparam int MAX_ALPHABET_DEF = 16;
  localparam int COUNT_BITS_DEF   = 32;

  // Fixed field widths.
  localparam int SYM_W   = 4;
  localparam int IDX_W   = 8;
  localparam int ALPHA_W = 5;
  localparam int OUT_W   = 32;
  // A pair bin is at most 15 * 31 + 15, which needs nine bits.
  localparam int BIN_W   = 9;

  // Bins that a read can ever address.
  localparam int IDX_DEPTH = 1 << IDX_W;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(16);

  // Operation carried in tuser.
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_READ = 1'b1
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture an input transfer and start the memory read
    logic write;     // write back the incremented count of a push
    logic out_load;  // move a read result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;   // the item in flight is a read
  } dp_status_t;

endpackage
`default_nettype wire

@@ rtl/sphist_ctrl.sv @@
// Controller state machine of the symbol pair histogram.
`default_nettype none
module sphist_ctrl (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     s_valid_i,
  input  wire                     m_ready_i,
  input  sphist_pkg::dp_status_t  status_i,
  output logic                    s_ready_o,
  output logic                    m_valid_o,
  output sphist_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_ACCESS = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // The output register may take a new result when it is empty or being emptied.
  assign out_free  = !out_valid_q || m_ready_i;
  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = out_valid_q;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        if (status_i.is_read) begin
          if (out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.write = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // The output valid flag is set by a load and cleared by a completed transfer.
  assign out_valid_d = cmd_o.out_load || (out_valid_q && !m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/sphist_dp.sv @@
// Datapath of the symbol pair histogram: history, bin arithmetic and count memory.
`default_nettype none
module sphist_dp #(
  parameter int MAX_ALPHABET = sphist_pkg::MAX_ALPHABET_DEF,
  parameter int COUNT_BITS   = sphist_pkg::COUNT_BITS_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [sphist_pkg::ALPHA_W-1:0]     cfg_data_i,
  input  wire                                op_i,
  input  wire  [sphist_pkg::SYM_W-1:0]       symbol_i,
  input  wire                                start_i,
  input  wire  [sphist_pkg::IDX_W-1:0]       bin_index_i,
  input  sphist_pkg::ctrl_cmd_t              cmd_i,
  output sphist_pkg::dp_status_t             status_o,
  output logic [sphist_pkg::OUT_W-1:0]       pair_count_o
);

  localparam int SymW     = sphist_pkg::SYM_W;
  localparam int AlphaW   = sphist_pkg::ALPHA_W;
  localparam int BinW     = sphist_pkg::BIN_W;
  localparam int OutW     = sphist_pkg::OUT_W;
  localparam int HistDepth = MAX_ALPHABET * MAX_ALPHABET;
  // The memory is no deeper than the read range; pair bins beyond it are not stored.
  localparam int MemDepth = (HistDepth < sphist_pkg::IDX_DEPTH) ? HistDepth
                                                                 : sphist_pkg::IDX_DEPTH;
  localparam int AddrW    = $clog2(MemDepth);

  // Configuration and sequence history.
  logic [AlphaW-1:0] alpha_q;
  logic [SymW-1:0]   last_q, last_d;
  logic [SymW-1:0]   second_q, second_d;
  logic [1:0]        seen_q, seen_d;
  logic              counted_q, counted_d;
  logic              bump;

  // Item in flight.
  logic              is_read_q;
  logic              hit_q;
  logic              store_q;
  logic [AddrW-1:0]  addr_q;

  // Count memory with one valid bit per entry.
  logic [COUNT_BITS-1:0] mem [MemDepth];
  logic [MemDepth-1:0]   vld_q;
  logic [COUNT_BITS-1:0] rdata_q;
  logic                  rvld_q;

  logic [AlphaW-1:0]     stride;
  logic [BinW-1:0]       pair_bin;
  logic [AddrW-1:0]      raddr;
  logic                  hit;
  logic [COUNT_BITS-1:0] entry;
  logic [COUNT_BITS-1:0] entry_inc;
  logic [OutW-1:0]       cnt_out;
  logic [OutW-1:0]       out_q;

  // Configuration register; writes must arrive only while idle, not enforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= sphist_pkg::ALPHA_RESET;
    end else if (cfg_we_i) begin
      alpha_q <= cfg_data_i;
    end
  end

  // Row stride, clamped to the legal range.
  always_comb begin
    if (alpha_q == '0) begin
      stride = AlphaW'(1);
    end else if (32'(alpha_q) > MAX_ALPHABET) begin
      stride = AlphaW'(MAX_ALPHABET);
    end else begin
      stride = alpha_q;
    end
  end

  // Bin of the pair made by the last symbol and the incoming one.
  assign pair_bin = BinW'(BinW'(last_q) * BinW'(stride)) + BinW'(symbol_i);

  // Pair selection: overlapping repeats are counted only alternately.
  always_comb begin
    seen_d    = seen_q;
    counted_d = counted_q;
    bump      = 1'b0;
    priority if (start_i || seen_q == 2'd0) begin
      seen_d    = 2'd1;
      counted_d = 1'b0;
    end else if (seen_q == 2'd1) begin
      bump      = 1'b1;
      counted_d = 1'b1;
      seen_d    = 2'd2;
    end else if (second_q == last_q && last_q == symbol_i && counted_q) begin
      counted_d = 1'b0;
    end else begin
      bump      = 1'b1;
      counted_d = 1'b1;
    end
    second_d = last_q;
    last_d   = symbol_i;
  end

  // Memory address and range check of the incoming item.
  always_comb begin
    if (op_i == sphist_pkg::OP_READ) begin
      raddr = AddrW'(bin_index_i);
      hit   = 32'(bin_index_i) < MemDepth;
    end else begin
      raddr = AddrW'(pair_bin);
      hit   = bump && (32'(pair_bin) < MemDepth);
    end
  end

  // History and item control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= '0;
      second_q  <= '0;
      seen_q    <= '0;
      counted_q <= 1'b0;
      is_read_q <= 1'b0;
      hit_q     <= 1'b0;
      store_q   <= 1'b0;
    end else if (cmd_i.load) begin
      is_read_q <= (op_i == sphist_pkg::OP_READ);
      hit_q     <= hit;
      store_q   <= hit && (op_i == sphist_pkg::OP_PUSH);
      if (op_i == sphist_pkg::OP_PUSH) begin
        last_q    <= last_d;
        second_q  <= second_d;
        seen_q    <= seen_d;
        counted_q <= counted_d;
      end
    end
  end

  // Address of the item in flight, used again for the write-back.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q <= raddr;
    end
  end

  // Valid bits: an entry never written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        rvld_q <= vld_q[raddr];
      end
      if (cmd_i.write && store_q) begin
        vld_q[addr_q] <= 1'b1;
      end
    end
  end

  // Count memory: one read at load, one write-back in the access state.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rdata_q <= mem[raddr];
    end
    if (cmd_i.write && store_q) begin
      mem[addr_q] <= entry_inc;
    end
  end

  // Stored count and its saturating increment.
  assign entry     = (hit_q && rvld_q) ? rdata_q : '0;
  assign entry_inc = (&entry) ? entry : entry + COUNT_BITS'(1);

  // Fit the count to the output width.
  if (COUNT_BITS > OutW) begin : g_sat
    assign cnt_out = (|entry[COUNT_BITS-1:OutW]) ? '1 : entry[OutW-1:0];
  end else begin : g_ext
    assign cnt_out = OutW'(entry);
  end

  // Output data register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= cnt_out;
    end
  end

  assign pair_count_o     = out_q;
  assign status_o.is_read = is_read_q;

endmodule
`default_nettype wire

@@ rtl/symbol_pair_histogram_non_overlap.sv @@
// Top level of the symbol pair histogram with alternate counting of overlapping repeats.
//
// Items enter on the s_axis channel: tuser selects a push of one symbol or a read of
// one histogram bin. A push updates the pair history and, when the pair is counted,
// adds one to its bin (saturating); it produces no result. A read returns the bin's
// count on the m_axis channel. The cfg channel writes the alphabet size, which sets
// the row stride of the histogram; it is always ready, and the user must see that it
// is written only while idle, which the block does not enforce. Each item has a
// transfer cycle, which starts the single-port read of the count memory, and an
// access state that writes back the count or loads the result; owing to this
// read-modify-write, no new item is taken before the last one leaves the access
// state. A read result is held in an output register, so the next item is taken
// while it waits. A stalled receiver blocks only a second read, which waits in the
// access state until the output register empties. Reset clears the history and the
// alphabet size to sixteen, and clears the histogram at once through per-entry valid
// bits, so no clearing pass is needed and items are taken right after reset.
`default_nettype none
module symbol_pair_histogram_non_overlap #(
  parameter int MAX_ALPHABET = sphist_pkg::MAX_ALPHABET_DEF,
  parameter int COUNT_BITS   = sphist_pkg::COUNT_BITS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [4:0]  cfg_data_i,     // alphabet_in_use[4:0]
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // symbol[3:0], start_sequence[4], bin_index[12:5]
  input  wire         s_axis_tuser,   // op[0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata    // pair_count[31:0]
);

  sphist_pkg::ctrl_cmd_t  cmd;
  sphist_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  // Sequencing of each item and the output handshake.
  sphist_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_i  (status),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .cmd_o     (cmd)
  );

  // History, pair bins and the count memory.
  sphist_dp #(
    .MAX_ALPHABET (MAX_ALPHABET),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .op_i         (s_axis_tuser),
    .symbol_i     (s_axis_tdata[3:0]),
    .start_i      (s_axis_tdata[4]),
    .bin_index_i  (s_axis_tdata[12:5]),
    .cmd_i        (cmd),
    .status_o     (status),
    .pair_count_o (m_axis_tdata)
  );

endmodule
`default_nettype wire

@@ rtl/sphist_checker.sv @@
// Port-level checks of the symbol pair histogram and their binding to the top level.
`default_nettype none
module sphist_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        s_axis_tuser,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [31:0] m_axis_tdata
);

  // A result waiting for the receiver keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The block is busy in the cycle after every input transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken during the access cycle");

  // Every new result is preceded by a read transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready && s_axis_tuser == sphist_pkg::OP_READ, 2))
    else $error("result without a matching read");

  // A push transfer never starts a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == sphist_pkg::OP_PUSH && !m_axis_tvalid
      |=> ##1 !m_axis_tvalid)
    else $error("result produced by a push");

endmodule

bind symbol_pair_histogram_non_overlap sphist_checker u_sphist_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the symbol pair histogram with alternate counting of repeats.
`timescale 1ns / 100ps
module tb;

  localparam int HIST_BINS = 256;
  localparam int PHASES    = 6;
  localparam int RANDOM_PER_PHASE = 334;

  // One row of the directed stimulus table.
  typedef struct {
    sphist_pkg::op_e op;
    logic [3:0]  sym;
    logic        start;
    logic [7:0]  bin;
    logic        typed;
    logic [31:0] count;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // symbol[3:0], start_sequence[4], bin_index[12:5]
  logic        s_axis_tuser;   // op[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // pair_count[31:0]

  // Shadow state of the histogram, updated on every accepted transfer.
  logic [4:0]  alpha_shadow;
  logic [3:0]  newest_sym;
  logic [3:0]  older_sym;
  logic [1:0]  syms_in_window;
  logic        newest_pair_counted;
  logic [31:0] bin_counts [HIST_BINS];
  logic [7:0]  recent_bin;

  logic [31:0] expected_counts [$];
  int unsigned results_seen;
  int unsigned mismatch_count;

  symbol_pair_histogram_non_overlap uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // Generous ceiling on the whole run.
  initial begin : watchdog
    #20_000_000;
    $display("tb failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Row stride actually used: zero counts as one, anything above sixteen as sixteen.
  function automatic int unsigned eff_stride();
    if (alpha_shadow == 5'd0) return 1;
    if (alpha_shadow > 5'd16) return 16;
    return alpha_shadow;
  endfunction

  function automatic void count_pair(input logic [3:0] left, input logic [3:0] right);
    int unsigned pair_bin;
    pair_bin = left * eff_stride() + right;
    if (pair_bin < HIST_BINS) begin
      if (bin_counts[pair_bin] != 32'hFFFF_FFFF) bin_counts[pair_bin]++;
      recent_bin = pair_bin[7:0];
    end
  endfunction

  // Advances the shadow state by one item; returns 1 when the item yields a count.
  function automatic logic predict_pair_count(input sphist_pkg::op_e op,
                                              input logic [3:0] sym,
                                              input logic start, input logic [7:0] bin,
                                              output logic [31:0] count);
    logic repeat_run;
    count = 32'd0;
    if (op == sphist_pkg::OP_READ) begin
      count = bin_counts[bin];
      return 1'b1;
    end
    if (start || syms_in_window == 2'd0) begin
      syms_in_window      = 2'd1;
      newest_pair_counted = 1'b0;
    end else if (syms_in_window == 2'd1) begin
      count_pair(newest_sym, sym);
      newest_pair_counted = 1'b1;
      syms_in_window      = 2'd2;
    end else begin
      // An overlapping repeat is only counted when the one before it was not.
      repeat_run = (older_sym == newest_sym) && (newest_sym == sym);
      if (!repeat_run || !newest_pair_counted) begin
        count_pair(newest_sym, sym);
        newest_pair_counted = 1'b1;
      end else begin
        newest_pair_counted = 1'b0;
      end
    end
    older_sym  = newest_sym;
    newest_sym = sym;
    return 1'b0;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Offers one item, waits for its transfer, records the expectation, then idles for the gap, if any.
  task automatic send_item(input sphist_pkg::op_e op, input logic [3:0] sym,
                           input logic start,
                           input logic [7:0] bin, input logic typed,
                           input logic [31:0] typed_count, input int unsigned gap);
    logic [31:0] count;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, bin, start, sym};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_pair_count(op, sym, start, bin, count))
      expected_counts.push_back(typed ? typed_count : count);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Result side: checks each transfer and varies tready, with one long hold-off.
  initial begin : result_sink
    int unsigned hold_cnt;
    int unsigned low_len;
    logic        next_ready;
    logic        long_hold_done;
    logic [31:0] want;
    m_axis_tready  = 1'b0;
    hold_cnt       = 0;
    long_hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_counts.size() == 0) begin
          report_mismatch($sformatf("unexpected result pair_count=%0d", m_axis_tdata));
        end else begin
          want = expected_counts.pop_front();
          if (m_axis_tdata !== want)
            report_mismatch($sformatf("pair_count got %0d, wanted %0d", m_axis_tdata, want));
        end
      end
      next_ready = m_axis_tready;
      if (!long_hold_done && results_seen >= 40) begin
        // Long stall so the block fills up and pushes back on its input.
        long_hold_done = 1'b1;
        next_ready     = 1'b0;
        hold_cnt       = 400;
      end else if (hold_cnt > 0) begin
        hold_cnt--;
      end else begin
        low_len = m_axis_tready ? pick_gap() : 0;
        if (low_len > 0) begin
          next_ready = 1'b0;
          hold_cnt   = low_len - 1;
        end else begin
          next_ready = 1'b1;
          hold_cnt   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(0, 5);
        end
      end
      m_axis_tready <= next_ready;
    end
  end

  initial begin : stimulus
    stim_row_t   directed_rows [$];
    int unsigned alpha_plan [PHASES];
    int unsigned burst_left;
    int unsigned gap;
    sphist_pkg::op_e op;
    logic [3:0]  sym;
    logic [3:0]  last_sent_sym;
    logic        start;
    logic [7:0]  bin;
    int unsigned r;

    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 5'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 16'd0;
    s_axis_tuser  = sphist_pkg::OP_PUSH;
    results_seen  = 0;
    mismatch_count = 0;
    burst_left    = 0;
    last_sent_sym = 4'd0;

    alpha_shadow        = sphist_pkg::ALPHA_RESET;
    newest_sym          = 4'd0;
    older_sym           = 4'd0;
    syms_in_window      = 2'd0;
    newest_pair_counted = 1'b0;
    recent_bin          = 8'd0;
    foreach (bin_counts[i]) bin_counts[i] = 32'd0;

    // Register settings per phase: reset value, both out-of-range ends, one, just above the range, a middle one.
    alpha_plan = '{16, 0, 1, 31, 17, 7};
    alpha_plan[PHASES-1] = $urandom_range(2, 15);

    // Empty histogram after reset, the first push without a start flag,
    // a run of repeats that is counted only alternately, start flags that
    // drop the history, and the extreme symbols and bins.
    directed_rows.push_back('{sphist_pkg::OP_READ, 4'd0,  1'b0, 8'd0,   1'b1, 32'd0});
    directed_rows.push_back('{sphist_pkg::OP_READ, 4'd0,  1'b0, 8'd255, 1'b1, 32'd0});
    directed_rows.push_back('{sphist_pkg::OP_PUSH, 4'd3,  1'b0, 8'd0,   1'b0, 32'd0});
    directed_rows.push_back('{sphist_pkg::OP_PUSH, 4'd3,  1'b0, 8'd0,   1'b0, 32'd0});
    directed_rows.push_back('{sphist_pkg::OP_PUSH, 4'd3,  1'b0, 8'd0,   1'b0, 32'd0});
    directed_rows.push_back('{sphist_pkg::OP_PUSH, 4'd3,  1'b0, 8'd0,   1'b0, 32'd0});
    directed_rows.push_back('{sphist_pkg::OP_PUSH, 4'd3,  1'b0, 8'd0,   1'b0, 32'd0});
    directed_rows.push_back('{sphist_pkg::OP_READ, 4'd0,  1'b0, 8'd51,  1'b0, 32'd0});
    directed_rows.push_back('{sphist_pkg::OP_PUSH, 4'd15, 1'b1, 8'd0,   1'b0, 32'd0});
    directed_rows.push_back('{sphist_pkg::OP_PUSH, 4'd15, 1'b0, 8'd0,   1'b0, 32'd0});
    directed_rows.push_back('{sphist_pkg::OP_READ, 4'd15, 1'b0, 8'd255, 1'b0, 32'd0});
    directed_rows.push_back('{sphist_pkg::OP_PUSH, 4'd0,  1'b0, 8'd0,   1'b0, 32'd0});
    directed_rows.push_back('{sphist_pkg::OP_PUSH, 4'd0,  1'b1, 8'd0,   1'b0, 32'd0});
    directed_rows.push_back('{sphist_pkg::OP_PUSH, 4'd0,  1'b0, 8'd0,   1'b0, 32'd0});
    directed_rows.push_back('{sphist_pkg::OP_PUSH, 4'd0,  1'b0, 8'd0,   1'b0, 32'd0});
    directed_rows.push_back('{sphist_pkg::OP_PUSH, 4'd15, 1'b0, 8'd0,   1'b0, 32'd0});
    directed_rows.push_back('{sphist_pkg::OP_READ, 4'd0,  1'b1, 8'd240, 1'b0, 32'd0});
    directed_rows.push_back('{sphist_pkg::OP_READ, 4'd0,  1'b0, 8'd0,   1'b0, 32'd0});
    directed_rows.push_back('{sphist_pkg::OP_READ, 4'd0,  1'b0, 8'd15,  1'b0, 32'd0});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < PHASES; phase++) begin
      // Only reconfigure once the block has drained.
      while (expected_counts.size() != 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);
      cfg_valid_i <= 1'b1;
      cfg_data_i  <= alpha_plan[phase][4:0];
      do @(posedge clk_i); while (!cfg_ready_o);
      alpha_shadow = alpha_plan[phase][4:0];
      cfg_valid_i <= 1'b0;

      if (phase == 0) begin
        foreach (directed_rows[i])
          send_item(directed_rows[i].op, directed_rows[i].sym, directed_rows[i].start,
                    directed_rows[i].bin, directed_rows[i].typed, directed_rows[i].count,
                    pick_gap());
      end

      // Mostly runs of repeats and in-alphabet symbols, with reads of live and random bins.
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        op    = ($urandom_range(0, 99) < 30) ? sphist_pkg::OP_READ : sphist_pkg::OP_PUSH;
        start = ($urandom_range(0, 99) < 8);
        r     = $urandom_range(0, 99);
        if (r < 50)      sym = last_sent_sym;
        else if (r < 80) sym = 4'($urandom_range(0, eff_stride() - 1));
        else             sym = 4'($urandom_range(0, 15));
        bin = ($urandom_range(0, 1) == 0) ? recent_bin : 8'($urandom_range(0, 255));
        if (op == sphist_pkg::OP_PUSH) last_sent_sym = sym;

        if (burst_left > 0) begin
          burst_left--;
          gap = 0;
        end else if ($urandom_range(0, 49) == 0) begin
          burst_left = $urandom_range(20, 60);
          gap = 0;
        end else begin
          gap = pick_gap();
        end
        send_item(op, sym, start, bin, 1'b0, 32'd0, gap);
      end
      s_axis_tvalid <= 1'b0;
    end

    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
